[rtl/core/fba_pkg.sv]
// fba_pkg: types and constants shared by the frame bitmap allocator files
// holds request/response structs, operation and status codes, fsm states
// no dependencies
package fba_pkg;

   // frame map geometry
   localparam int MAX_FRAMES    = 4096;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = MAX_FRAMES / MAP_WORD_BITS;
   localparam int FRAME_W       = 12;
   localparam int BIT_W         = 5;
   localparam int WORD_W        = 7;
   localparam int BOUND_W       = 13;
   localparam int PAGE_SHIFT    = 12;
   localparam int ADDR_W        = 24;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_FRAMES_IN_USE = 1'b0;
   localparam logic [BOUND_W-1:0] FRAMES_RESET = 13'd4096;
   localparam logic [BOUND_W-1:0] FRAMES_MAX   = 13'd4096;

   typedef enum logic [2:0] {
      FUNC_ALLOC  = 3'd0,
      FUNC_FREE   = 3'd1,
      FUNC_MARK   = 3'd2,
      FUNC_UNMARK = 3'd3,
      FUNC_TEST   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOOP     = 2'd1,
      ST_NO_FRAME = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MODIFY,
      S_FINISH
   } state_type;

   typedef struct packed {
      func_type           func;
      logic [ADDR_W-1:0]  byte_address;
      logic [FRAME_W-1:0] current_frame;
      logic               for_kernel;
      logic               writeable;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               present;
      logic               read_write;
      logic               user_access;
      logic               bit_set;
      status_type         status;
   } rsp_type;

endpackage

[rtl/core/fba_ram.sv]
// fba_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/frame_bitmap_allocator.sv]
// frame_bitmap_allocator: first-fit allocator over a bitmap of 4 KiB frames
// depends on fba_pkg and fba_ram (128 x 32 map memory)
//
//   port group  | handshake              | payload
//   ------------+------------------------+------------------------------
//   req_        | req_valid / req_ready  | req_data (fba_pkg::req_type)
//   rsp_        | rsp_valid / rsp_ready  | rsp_data (fba_pkg::rsp_type)
//   csr_        | apb write, pready high | frames_in_use at address 0
//
// allocate scans k = 1..128 map words in order from word 0, one word per
// cycle through the registered read port of the map memory
// free, mark, unmark and test go through read, modify-write and finish;
// requests settled without the map skip the modify-write step
// one request is in flight at a time; a new request is taken while the
// previous response still waits in the output register
// reset is synchronous; per-word valid bits make the map read as all free
module frame_bitmap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fba_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fba_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import fba_pkg::*;

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   rsp_type                  res_ff, res_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        word_ff, word_in;
   logic [BOUND_W-1:0]       frames_ff, frames_in;
   logic [MAP_WORDS-1:0]     valid_ff;

   logic                     ram_wr_en;
   logic [WORD_W-1:0]        ram_wr_addr;
   logic [MAP_WORD_BITS-1:0] ram_wr_data;
   logic                     ram_rd_en;
   logic [WORD_W-1:0]        ram_rd_addr;
   logic [MAP_WORD_BITS-1:0] ram_rd_data;

   logic [BOUND_W-1:0]       bound;
   logic                     accept;
   logic                     slot_free;
   logic                     csr_write;
   logic [FRAME_W-1:0]       req_af;
   logic                     req_cur_zero;
   logic                     req_cur_out;
   logic                     req_af_out;
   logic                     go_scan;
   logic                     go_modify;
   logic [MAP_WORD_BITS-1:0] word_data;
   logic                     word_full;
   logic [MAP_WORD_BITS-1:0] zero_onehot;
   logic [BIT_W-1:0]         zero_bit;
   logic [FRAME_W-1:0]       found_frame;
   logic                     alloc_ok;
   logic [WORD_W:0]          word_next;
   logic                     scan_end;
   logic [FRAME_W-1:0]       held_af;
   logic [BIT_W-1:0]         bit_idx;
   logic [MAP_WORD_BITS-1:0] bit_mask;

   // map memory
   fba_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign frames_in  = (csr_write && csr_paddr[2] == CSR_IDX_FRAMES_IN_USE)
                       ? csr_pwdata[BOUND_W-1:0] : frames_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FRAMES_IN_USE)
                       ? {{(CSR_DATA_W-BOUND_W){1'b0}}, frames_ff} : '0;
   assign bound      = (frames_ff > FRAMES_MAX) ? FRAMES_MAX : frames_ff;

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // decode of an incoming request
   assign req_af       = req_data.byte_address[PAGE_SHIFT +: FRAME_W];
   assign req_cur_zero = (req_data.current_frame == '0);
   assign req_cur_out  = ({1'b0, req_data.current_frame} >= bound);
   assign req_af_out   = ({1'b0, req_af} >= bound);
   assign go_scan      = (req_data.func == FUNC_ALLOC) & req_cur_zero;
   always_comb begin
      case (req_data.func) inside
         FUNC_FREE:                          go_modify = ~req_cur_zero & ~req_cur_out;
         FUNC_MARK, FUNC_UNMARK, FUNC_TEST:  go_modify = ~req_af_out;
         default:                            go_modify = 1'b0;
      endcase
   end

   // word returned by the memory, never-written words read as free
   assign word_data   = valid_ff[word_ff] ? ram_rd_data : '0;
   assign word_full   = &word_data;
   assign zero_onehot = ~word_data & (word_data + MAP_WORD_BITS'(1));
   always_comb begin
      zero_bit = '0;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         if (zero_onehot[i]) begin
            zero_bit = zero_bit | BIT_W'(i);
         end
      end
   end
   assign found_frame = {word_ff, zero_bit};
   assign alloc_ok    = ~word_full & ({1'b0, found_frame} < bound);
   assign word_next   = {1'b0, word_ff} + (WORD_W+1)'(1);
   assign scan_end    = ({word_next, {BIT_W{1'b0}}} >= bound);

   // bit addressed by a held free, mark, unmark or test request
   assign held_af  = req_ff.byte_address[PAGE_SHIFT +: FRAME_W];
   assign bit_idx  = (req_ff.func == FUNC_FREE) ? req_ff.current_frame[BIT_W-1:0]
                                               : held_af[BIT_W-1:0];
   assign bit_mask = MAP_WORD_BITS'(1) << bit_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (go_scan) begin
                  state_in = S_SCAN;
               end else if (go_modify) begin
                  state_in = S_MODIFY;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (~word_full || scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_MODIFY: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      word_in      = word_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = word_next[WORD_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = word_ff;
      ram_wr_data  = word_data;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               ram_rd_en = 1'b1;
               res_in    = '0;
               res_in.status = ST_DONE;
               case (req_data.func) inside
                  FUNC_ALLOC: begin
                     ram_rd_addr = '0;
                     if (!req_cur_zero) begin
                        res_in.frame_index = req_data.current_frame;
                        res_in.status      = ST_NOOP;
                     end
                  end
                  FUNC_FREE: begin
                     ram_rd_addr = req_data.current_frame[FRAME_W-1:BIT_W];
                     if (req_cur_zero) begin
                        res_in.status = ST_NOOP;
                     end else if (req_cur_out) begin
                        res_in.frame_index = req_data.current_frame;
                        res_in.status      = ST_RANGE;
                     end
                  end
                  FUNC_MARK, FUNC_UNMARK, FUNC_TEST: begin
                     ram_rd_addr = req_af[FRAME_W-1:BIT_W];
                     if (req_af_out) begin
                        res_in.status = ST_RANGE;
                     end
                  end
                  default: begin
                     ram_rd_en     = 1'b0;
                     res_in.status = ST_NOOP;
                  end
               endcase
               word_in = ram_rd_addr;
            end
         end
         S_SCAN: begin
            // keep the read port one word ahead
            ram_rd_en = 1'b1;
            if (!word_full) begin
               if (alloc_ok) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_data        = word_data | zero_onehot;
                  res_in.frame_index = found_frame;
                  res_in.present     = 1'b1;
                  res_in.read_write  = req_ff.writeable;
                  res_in.user_access = ~req_ff.for_kernel;
               end else begin
                  res_in.status = ST_NO_FRAME;
               end
            end else if (scan_end) begin
               res_in.status = ST_NO_FRAME;
            end else begin
               word_in = word_next[WORD_W-1:0];
            end
         end
         S_MODIFY: begin
            case (req_ff.func) inside
               FUNC_MARK: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = word_data | bit_mask;
               end
               FUNC_FREE, FUNC_UNMARK: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = word_data & ~bit_mask;
               end
               default: begin
                  res_in.bit_set = |(word_data & bit_mask);
               end
            endcase
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= FRAMES_RESET;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         frames_ff    <= frames_in;
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/core/fba_checker.sv]
// fba_checker: port-level assertions for frame_bitmap_allocator
// depends on fba_pkg; bound to the top level at the end of this file
module fba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fba_pkg::rsp_type rsp_data
);
   import fba_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request in flight: ready drops after each accepted request
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a present page entry only comes from a completed allocate
   a_present_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.present |-> rsp_data.status == ST_DONE && !rsp_data.bit_set)
      else $error("present entry with failing status");

   // failed allocate returns an empty entry
   a_no_frame_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NO_FRAME
      |-> rsp_data.frame_index == '0 && !rsp_data.present && !rsp_data.bit_set)
      else $error("no-frame response carries an entry");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

[tb/sv/frame_map_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// frame_map_scoreboard_pkg: predictor and response checker for the frame allocator
// keeps its own copy of the frame bitmap and bound, depends on fba_pkg
package frame_map_scoreboard_pkg;

   import fba_pkg::*;

   class frame_map_scoreboard;

      bit                 frame_used [MAX_FRAMES];
      logic [BOUND_W-1:0] frames_in_use;
      rsp_type            expected_q [$];
      int                 errors;

      function new();
         foreach (frame_used[i]) frame_used[i] = 1'b0;
         frames_in_use = FRAMES_RESET;
         errors        = 0;
      endfunction

      function void write_frames_in_use(logic [CSR_DATA_W-1:0] value);
         frames_in_use = value[BOUND_W-1:0];
      endfunction

      // compute the page entry and status of one request, updating the map
      function rsp_type predict_allocation(req_type r);
         rsp_type     res;
         int unsigned lim;
         int unsigned af;
         bit          found;
         res        = '0;
         res.status = ST_DONE;
         lim        = 32'((frames_in_use > FRAMES_MAX) ? FRAMES_MAX : frames_in_use);
         af         = 32'(r.byte_address[ADDR_W-1:PAGE_SHIFT]);
         found      = 1'b0;
         case (r.func) inside
            FUNC_ALLOC: begin
               if (r.current_frame != 0) begin
                  res.frame_index = r.current_frame;
                  res.status      = ST_NOOP;
               end else begin
                  // first fit below the bound
                  for (int i = 0; i < lim; i++) begin
                     if (!frame_used[i]) begin
                        frame_used[i]   = 1'b1;
                        res.frame_index = FRAME_W'(i);
                        res.present     = 1'b1;
                        res.read_write  = r.writeable;
                        res.user_access = ~r.for_kernel;
                        found           = 1'b1;
                        break;
                     end
                  end
                  if (!found) res.status = ST_NO_FRAME;
               end
            end
            FUNC_FREE: begin
               if (r.current_frame == 0) begin
                  res.status = ST_NOOP;
               end else if (r.current_frame >= lim) begin
                  res.frame_index = r.current_frame;
                  res.status      = ST_RANGE;
               end else begin
                  frame_used[r.current_frame] = 1'b0;
               end
            end
            FUNC_MARK, FUNC_UNMARK, FUNC_TEST: begin
               if (af >= lim) begin
                  res.status = ST_RANGE;
               end else if (r.func == FUNC_MARK) begin
                  frame_used[af] = 1'b1;
               end else if (r.func == FUNC_UNMARK) begin
                  frame_used[af] = 1'b0;
               end else begin
                  res.bit_set = frame_used[af];
               end
            end
            default: res.status = ST_NOOP;
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(predict_allocation(r));
      endfunction

      function void report(string field, logic [31:0] exp, logic [31:0] act);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
      endfunction

      // compare one response against the oldest pending entry
      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, got);
            return;
         end
         exp = expected_q.pop_front();
         if (got.frame_index !== exp.frame_index)
            report("frame_index", 32'(exp.frame_index), 32'(got.frame_index));
         if (got.present !== exp.present)
            report("present", 32'(exp.present), 32'(got.present));
         if (got.read_write !== exp.read_write)
            report("read_write", 32'(exp.read_write), 32'(got.read_write));
         if (got.user_access !== exp.user_access)
            report("user_access", 32'(exp.user_access), 32'(got.user_access));
         if (got.bit_set !== exp.bit_set)
            report("bit_set", 32'(exp.bit_set), 32'(got.bit_set));
         if (got.status !== exp.status)
            report("status", 32'(exp.status), 32'(got.status));
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            errors += expected_q.size();
            $display("%0t: %0d responses missing, expected %h, actual none",
                     $time, expected_q.size(), expected_q[0]);
         end
      endfunction

   endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// testbench: drives the frame bitmap allocator through request, response and apb ports
// depends on fba_pkg, frame_map_scoreboard_pkg and the frame_bitmap_allocator rtl
module testbench;

   import fba_pkg::*;
   import frame_map_scoreboard_pkg::*;

   localparam int unsigned DRAIN_CYCLES   = 150;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_OFF       = 300;
   localparam int unsigned RANDOM_BOUND   = 32'hFFFF;
   localparam int unsigned PHASES         = 9;
   localparam logic [CSR_ADDR_W-1:0] FRAMES_IN_USE_ADDR =
      CSR_ADDR_W'(4 * CSR_IDX_FRAMES_IN_USE);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_map_scoreboard sb;
   int unsigned         cur_bound      = 4096;
   bit                  idle_enable    = 1'b1;
   bit                  hold_off_armed = 1'b0;
   int unsigned         idle_cycles    = 0;

   frame_bitmap_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == FRAMES_IN_USE_ADDR)
            sb.write_frames_in_use(csr_pwdata);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side: random stalls, one long hold-off when armed
   initial begin : receiver
      int unsigned gap;
      bit          hold_off_done;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_off_armed && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         gap = idle_enable ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type make_request(func_type f, logic [ADDR_W-1:0] a,
                                            logic [FRAME_W-1:0] c, bit k, bit w);
      req_type r;
      r.func          = f;
      r.byte_address  = a;
      r.current_frame = c;
      r.for_kernel    = k;
      r.writeable     = w;
      return r;
   endfunction

   // random request, addresses and frames biased toward the managed range
   function automatic req_type random_request(int unsigned alloc_pct);
      req_type     r;
      int unsigned span;
      int unsigned near;
      int unsigned pick;
      int unsigned frame;
      span = (cur_bound + 4 > 4095) ? 4095 : cur_bound + 4;
      near = (span < 200) ? span : 200;
      r    = '0;
      if ($urandom_range(0, 99) < alloc_pct) begin
         r.func = FUNC_ALLOC;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick < 5)       r.func = FUNC_FREE;
         else if (pick < 9)  r.func = FUNC_MARK;
         else if (pick < 12) r.func = FUNC_UNMARK;
         else if (pick < 18) r.func = FUNC_TEST;
         else                r.func = func_type'(3'(5 + $urandom_range(0, 2)));
      end
      pick  = $urandom_range(0, 3);
      frame = (pick < 2) ? $urandom_range(0, near) :
              (pick == 2) ? $urandom_range(0, span) : $urandom_range(0, 4095);
      r.byte_address = {FRAME_W'(frame), 12'($urandom_range(0, 4095))};
      pick = $urandom_range(0, 9);
      if (r.func == FUNC_ALLOC)
         r.current_frame = (pick < 7) ? '0 : FRAME_W'($urandom_range(0, 4095));
      else if (r.func == FUNC_FREE)
         r.current_frame = (pick == 0) ? '0 :
                           (pick < 5) ? FRAME_W'($urandom_range(1, near)) :
                           (pick < 8) ? FRAME_W'($urandom_range(1, span)) :
                           FRAME_W'($urandom_range(0, 4095));
      else
         r.current_frame = FRAME_W'($urandom_range(0, 4095));
      r.for_kernel = 1'($urandom_range(0, 1));
      r.writeable  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = idle_enable ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every request has its response
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_frames_in_use(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FRAMES_IN_USE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_bound = 32'((value[BOUND_W-1:0] > FRAMES_MAX) ? FRAMES_MAX
                                                          : value[BOUND_W-1:0]);
   endtask

   initial begin : stimulus
      int unsigned phase_bound [PHASES] = '{32, 4096, 160, 0, 8191, RANDOM_BOUND, 1,
                                            4096, RANDOM_BOUND};
      int unsigned phase_alloc [PHASES] = '{40, 35, 70, 30, 50, 40, 40, 30, 45};
      int unsigned phase_items [PHASES] = '{120, 150, 200, 40, 150, 150, 60, 160, 120};
      logic [CSR_DATA_W-1:0] value;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full bound: allocate, held entry, free, address operations
      write_frames_in_use(32'd4096);
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b0));
      send_request(make_request(FUNC_ALLOC, 24'hFFFFFF, 12'h000, 1'b0, 1'b1));
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b1));
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'hFFF, 1'b0, 1'b1));
      send_request(make_request(FUNC_FREE,  24'h000000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_FREE,  24'h000000, 12'h001, 1'b1, 1'b1));
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'h000, 1'b0, 1'b1));
      send_request(make_request(FUNC_TEST,  24'h000000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_TEST,  24'hFFFFFF, 12'hFFF, 1'b1, 1'b1));
      send_request(make_request(FUNC_MARK,  24'hFFFFFF, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_TEST,  24'hFFFFFF, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_FREE,  24'h000000, 12'hFFF, 1'b0, 1'b0));
      send_request(make_request(FUNC_TEST,  24'hFFF000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_MARK,  24'h00AFFF, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_UNMARK, 24'h001000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_TEST,  24'h001ABC, 12'h000, 1'b0, 1'b0));
      // codes outside the operation set
      send_request(make_request(func_type'(3'd5), 24'h000000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(func_type'(3'd6), 24'hFFFFFF, 12'hFFF, 1'b1, 1'b1));
      send_request(make_request(func_type'(3'd7), 24'h000000, 12'h000, 1'b0, 1'b0));
      wait_for_responses();

      // zero bound: nothing can be allocated or addressed
      write_frames_in_use(32'd0);
      send_request(make_request(FUNC_ALLOC, 24'h000000, 12'h000, 1'b0, 1'b1));
      send_request(make_request(FUNC_TEST,  24'h000000, 12'h000, 1'b0, 1'b0));
      send_request(make_request(FUNC_FREE,  24'h000000, 12'h001, 1'b0, 1'b0));
      send_request(make_request(FUNC_MARK,  24'h000FFF, 12'h000, 1'b0, 1'b0));
      wait_for_responses();

      // random phases, map carried over between bounds
      for (int p = 0; p < PHASES; p++) begin
         value = phase_bound[p];
         if (value == RANDOM_BOUND)
            value = {19'($urandom()), 13'($urandom_range(33, 4095))};
         write_frames_in_use(value);
         idle_enable = !(p == 1 || p == 5);
         if (p == 0) hold_off_armed = 1'b1;
         for (int i = 0; i < phase_items[p]; i++)
            send_request(random_request(phase_alloc[p]));
         wait_for_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
